>>> design/fbc_pkg.sv
// Shared types and constants for the filled-circle framebuffer.
// Used by every module of the block except fbc_queue; depends on nothing.
`default_nettype none

package fbc_pkg;

  localparam int ACTION_W    = 2;
  localparam int POS_W       = 9;
  localparam int RADIUS_W    = 7;
  localparam int COLS_W      = 8;
  localparam int ROWS_W      = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  // Signed width for centre +/- radius and for area limits up to 1024.
  localparam int COORD_W = 12;
  // Offsets inside the bounding square never exceed the radius.
  localparam int DELTA_W = RADIUS_W + 1;
  localparam int RSQ_W   = 2 * RADIUS_W;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 32;

  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  localparam logic [COLS_W-1:0] RESET_ACTIVE_COLUMNS = COLS_W'(100);
  localparam logic [ROWS_W-1:0] RESET_ACTIVE_ROWS    = ROWS_W'(30);

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COLUMNS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_ROWS    = CFG_INDEX_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    cell_value;
    action_t done_action;
  } result_t;

endpackage

`default_nettype wire

>>> design/fbc_queue.sv
// Small synchronous FIFO built from flip-flops.
// Used between the front and back parts and for the results; no package use.
`default_nettype none

module fbc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> design/fbc_front.sv
// Front part: classifies each request and clips its cell range to the active area.
// Depends on fbc_pkg; feeds the command queue read by fbc_back.
`default_nettype none

module fbc_front #(
  parameter int MAX_COLUMNS = fbc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = fbc_pkg::DEF_MAX_ROWS,
  parameter int CMD_W       = 64
) (
  input  wire logic [fbc_pkg::ACTION_W-1:0] action,
  input  wire logic [fbc_pkg::POS_W-1:0]    pos_x,
  input  wire logic [fbc_pkg::POS_W-1:0]    pos_y,
  input  wire logic [fbc_pkg::RADIUS_W-1:0] radius,
  input  wire logic [fbc_pkg::COLS_W-1:0]   active_columns,
  input  wire logic [fbc_pkg::ROWS_W-1:0]   active_rows,
  output logic      [CMD_W-1:0]             cmd
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = fbc_pkg::COORD_W;

  fbc_pkg::action_t         act;
  logic signed [XW-1:0]     xe, ye, re;
  logic signed [XW-1:0]     lim_c, lim_r;
  logic signed [XW-1:0]     c_lo, c_hi, r_lo, r_hi;
  logic                     empty;
  logic [CW-1:0]            col_lo, col_hi;
  logic [RW-1:0]            row_lo, row_hi;
  logic [AW-1:0]            base;
  logic [fbc_pkg::RSQ_W-1:0] rsq;

  assign act = fbc_pkg::action_t'(action);
  assign xe  = XW'($signed(pos_x));
  assign ye  = XW'($signed(pos_y));
  assign re  = $signed(XW'(radius));

  assign lim_c = XW'(((XW'(active_columns) > XW'(MAX_COLUMNS)) ? $signed(XW'(MAX_COLUMNS))
                                                              : $signed(XW'(active_columns))) - 1);
  assign lim_r = XW'(((XW'(active_rows) > XW'(MAX_ROWS)) ? $signed(XW'(MAX_ROWS))
                                                        : $signed(XW'(active_rows))) - 1);

  always_comb begin
    if (act == fbc_pkg::ACT_DRAW) begin
      c_lo = (xe - re < 0) ? '0 : xe - re;
      c_hi = (xe + re > lim_c) ? lim_c : xe + re;
      r_lo = (ye - re < 0) ? '0 : ye - re;
      r_hi = (ye + re > lim_r) ? lim_r : ye + re;
    end else begin
      c_lo = xe;
      c_hi = xe;
      r_lo = ye;
      r_hi = ye;
    end
  end

  assign empty = (c_lo < 0) || (c_hi > lim_c) || (c_lo > c_hi) ||
                 (r_lo < 0) || (r_hi > lim_r) || (r_lo > r_hi);

  assign col_lo = c_lo[CW-1:0];
  assign col_hi = c_hi[CW-1:0];
  assign row_lo = r_lo[RW-1:0];
  assign row_hi = r_hi[RW-1:0];
  assign base   = AW'(32'(row_lo) * MAX_COLUMNS);
  assign rsq    = fbc_pkg::RSQ_W'(radius) * fbc_pkg::RSQ_W'(radius);

  assign cmd = {action, empty, col_lo, col_hi, row_lo, row_hi, base, xe, ye, rsq};

endmodule

`default_nettype wire

>>> design/fbc_back.sv
// Back part: owns the cell memory and carries out clear, draw and read one cell per cycle.
// Depends on fbc_pkg; takes commands laid out by fbc_front and pushes result_t items.
`default_nettype none

module fbc_back #(
  parameter int MAX_COLUMNS = fbc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = fbc_pkg::DEF_MAX_ROWS,
  parameter int CMD_W       = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_empty,
  input  wire logic [CMD_W-1:0] cmd_data,
  output logic                  cmd_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output fbc_pkg::result_t      res_data,
  output logic                  init_busy
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = fbc_pkg::COORD_W;
  localparam int DW    = fbc_pkg::DELTA_W;
  localparam int SQ_W  = 2 * DW;

  logic [fbc_pkg::ACTION_W-1:0] c_act_bits;
  fbc_pkg::action_t             c_act;
  logic                         c_empty;
  logic [CW-1:0]                c_col_lo, c_col_hi;
  logic [RW-1:0]                c_row_lo, c_row_hi;
  logic [AW-1:0]                c_base;
  logic signed [XW-1:0]         c_cx, c_cy;
  logic [fbc_pkg::RSQ_W-1:0]    c_rsq;

  assign {c_act_bits, c_empty, c_col_lo, c_col_hi, c_row_lo, c_row_hi,
          c_base, c_cx, c_cy, c_rsq} = cmd_data;
  assign c_act = fbc_pkg::action_t'(c_act_bits);

  fbc_pkg::state_t           state_r, state_nxt;
  fbc_pkg::action_t          act_r;
  logic [AW-1:0]             addr_r, base_r;
  logic [CW-1:0]             col_r, col_lo_r, col_hi_r;
  logic [RW-1:0]             row_r, row_hi_r;
  logic signed [XW-1:0]      cx_r, cy_r;
  logic [fbc_pkg::RSQ_W-1:0] rsq_r;
  logic                      cell_r;

  logic mem [DEPTH];
  logic          mem_we, mem_wd, rd_en, rd_data_r;
  logic [AW-1:0] mem_wa, rd_addr;

  logic signed [XW-1:0]   dx_full, dy_full;
  logic signed [DW-1:0]   dx, dy;
  logic signed [SQ_W-1:0] dx_sq, dy_sq;
  logic [SQ_W:0]          dist_sq;
  logic                   in_disc;
  logic                   sweep_last, draw_last;

  assign dx_full = $signed(XW'(col_r)) - cx_r;
  assign dy_full = $signed(XW'(row_r)) - cy_r;
  assign dx      = dx_full[DW-1:0];
  assign dy      = dy_full[DW-1:0];
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign dist_sq = {1'b0, $unsigned(dx_sq)} + {1'b0, $unsigned(dy_sq)};
  assign in_disc = (dist_sq <= (SQ_W+1)'(rsq_r));

  assign sweep_last = (addr_r == AW'(DEPTH - 1));
  assign draw_last  = (col_r == col_hi_r) && (row_r == row_hi_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbc_pkg::ST_INIT: begin
        if (sweep_last) state_nxt = fbc_pkg::ST_IDLE;
      end
      fbc_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          case (c_act)
            fbc_pkg::ACT_CLEAR: state_nxt = fbc_pkg::ST_CLEAR;
            fbc_pkg::ACT_DRAW:  state_nxt = c_empty ? fbc_pkg::ST_DONE : fbc_pkg::ST_DRAW;
            fbc_pkg::ACT_READ:  state_nxt = c_empty ? fbc_pkg::ST_DONE : fbc_pkg::ST_READ;
            default:            state_nxt = fbc_pkg::ST_DONE;
          endcase
        end
      end
      fbc_pkg::ST_CLEAR: begin
        if (sweep_last) state_nxt = fbc_pkg::ST_DONE;
      end
      fbc_pkg::ST_DRAW: begin
        if (draw_last) state_nxt = fbc_pkg::ST_DONE;
      end
      fbc_pkg::ST_READ: state_nxt = fbc_pkg::ST_DONE;
      fbc_pkg::ST_DONE: begin
        if (!res_full) state_nxt = fbc_pkg::ST_IDLE;
      end
      default: state_nxt = fbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    mem_wa    = addr_r;
    rd_en     = 1'b0;
    rd_addr   = c_base + AW'(c_col_lo);
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    init_busy = 1'b0;
    case (state_r)
      fbc_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        init_busy = 1'b1;
      end
      fbc_pkg::ST_IDLE: begin
        cmd_pop = !cmd_empty;
        rd_en   = !cmd_empty && (c_act == fbc_pkg::ACT_READ) && !c_empty;
      end
      fbc_pkg::ST_CLEAR: mem_we = 1'b1;
      fbc_pkg::ST_DRAW: begin
        mem_we = in_disc;
        mem_wd = 1'b1;
        mem_wa = base_r + AW'(col_r);
      end
      fbc_pkg::ST_DONE: res_push = !res_full;
      default: ;
    endcase
  end

  assign res_data.cell_value  = cell_r;
  assign res_data.done_action = act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbc_pkg::ST_INIT;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == fbc_pkg::ST_INIT) || (state_r == fbc_pkg::ST_CLEAR)) begin
        addr_r <= sweep_last ? '0 : addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fbc_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          act_r    <= c_act;
          col_r    <= c_col_lo;
          col_lo_r <= c_col_lo;
          col_hi_r <= c_col_hi;
          row_r    <= c_row_lo;
          row_hi_r <= c_row_hi;
          base_r   <= c_base;
          cx_r     <= c_cx;
          cy_r     <= c_cy;
          rsq_r    <= c_rsq;
          cell_r   <= 1'b0;
        end
      end
      fbc_pkg::ST_DRAW: begin
        if (col_r == col_hi_r) begin
          col_r  <= col_lo_r;
          row_r  <= row_r + 1'b1;
          base_r <= base_r + AW'(MAX_COLUMNS);
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      fbc_pkg::ST_READ: cell_r <= rd_data_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/filled_circle_framebuffer.sv
// Top level of the filled-circle framebuffer: configuration registers, front, queues, back.
// Depends on fbc_pkg, fbc_front, fbc_queue and fbc_back.
`default_nettype none

// The block keeps a MAX_COLUMNS x MAX_ROWS one-bit framebuffer and returns exactly one
// result for every request. Clear and draw go through the single write port of the
// memory, one cell per cycle, and read fetches one cell through a separate read port:
// clear writes every cell, draw visits each cell of the bounding square clipped to the
// active area (at most (2 * radius + 1)^2, none when nothing is left after clipping),
// and each request also passes the idle and done states of the back part. After reset
// the block blanks the memory in one pass and holds in_full high meanwhile;
// configuration writes are taken at any time and should only be issued while no
// request is pending.
module filled_circle_framebuffer #(
  parameter int MAX_COLUMNS = fbc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = fbc_pkg::DEF_MAX_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [fbc_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [fbc_pkg::POS_W-1:0]       in_pos_x,
  input  wire logic [fbc_pkg::POS_W-1:0]       in_pos_y,
  input  wire logic [fbc_pkg::RADIUS_W-1:0]    in_radius,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_cell_value,
  output logic      [fbc_pkg::ACTION_W-1:0]    out_done_action,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W = fbc_pkg::ACTION_W + 1 + 2 * CW + 2 * RW + AW +
                         2 * fbc_pkg::COORD_W + fbc_pkg::RSQ_W;
  localparam int RES_W = $bits(fbc_pkg::result_t);

  logic [fbc_pkg::COLS_W-1:0] active_columns_r;
  logic [fbc_pkg::ROWS_W-1:0] active_rows_r;

  logic             cmd_full, cmd_empty, cmd_pop, init_busy;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic             res_full, res_push;
  fbc_pkg::result_t res_data, res_head;
  logic [RES_W-1:0] res_head_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_columns_r <= fbc_pkg::RESET_ACTIVE_COLUMNS;
      active_rows_r    <= fbc_pkg::RESET_ACTIVE_ROWS;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fbc_pkg::CFG_ACTIVE_COLUMNS) begin
        active_columns_r <= cfg_data[fbc_pkg::COLS_W-1:0];
      end else if (cfg_index == fbc_pkg::CFG_ACTIVE_ROWS) begin
        active_rows_r <= cfg_data[fbc_pkg::ROWS_W-1:0];
      end
    end
  end

  assign in_full = cmd_full || init_busy;

  fbc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CMD_W       (CMD_W)
  ) u_front (
    .action         (in_action),
    .pos_x          (in_pos_x),
    .pos_y          (in_pos_y),
    .radius         (in_radius),
    .active_columns (active_columns_r),
    .active_rows    (active_rows_r),
    .cmd            (cmd_in)
  );

  fbc_queue #(
    .WIDTH (CMD_W),
    .DEPTH (fbc_pkg::CMD_Q_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push && !in_full),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  fbc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .init_busy (init_busy)
  );

  fbc_queue #(
    .WIDTH (RES_W),
    .DEPTH (fbc_pkg::RES_Q_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_head_bits),
    .empty   (out_empty)
  );

  assign res_head        = fbc_pkg::result_t'(res_head_bits);
  assign out_cell_value  = res_head.cell_value;
  assign out_done_action = res_head.done_action;

endmodule

`default_nettype wire

>>> design/fbc_checker.sv
// Port-level checks for the filled-circle framebuffer and the bind that attaches them.
// Depends on fbc_pkg and on the ports of filled_circle_framebuffer.
`default_nettype none

module fbc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_full,
  input wire logic                         out_empty,
  input wire logic                         out_pop,
  input wire logic                         out_cell_value,
  input wire logic [fbc_pkg::ACTION_W-1:0] out_done_action
);

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("Result shown right after reset.");

  a_init_blocks_requests: assert property (@(posedge clk) $rose(rst_n) |-> in_full)
    else $error("Request accepted while the memory is being blanked.");

  a_init_no_result: assert property (@(posedge clk) $rose(rst_n) |=> out_empty)
    else $error("Result shown before any request could finish.");

  a_cell_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
      !out_empty |-> (!out_cell_value || out_done_action == fbc_pkg::ACT_READ))
    else $error("Cell value set on a result that is not a read.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_cell_value) && $stable(out_done_action)))
    else $error("Waiting result changed or vanished.");

endmodule

bind filled_circle_framebuffer fbc_checker u_fbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_cell_value  (out_cell_value),
  .out_done_action (out_done_action)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for filled_circle_framebuffer: a queue-fed driver and a monitor
// compare every result against a bit-level framebuffer predictor kept in the bench.
// Depends on fbc_pkg and the filled_circle_framebuffer RTL.

module tb;

  localparam int MAX_COLS    = fbc_pkg::DEF_MAX_COLUMNS;
  localparam int MAX_ROWS_TB = fbc_pkg::DEF_MAX_ROWS;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int POP_HOLD    = 400;
  localparam int ACTION_W    = fbc_pkg::ACTION_W;
  localparam int POS_W       = fbc_pkg::POS_W;
  localparam int RADIUS_W    = fbc_pkg::RADIUS_W;
  localparam int COLS_W      = fbc_pkg::COLS_W;
  localparam int ROWS_W      = fbc_pkg::ROWS_W;
  localparam int CFG_INDEX_W = fbc_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = fbc_pkg::CFG_DATA_W;

  typedef struct {
    fbc_pkg::action_t    act;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [RADIUS_W-1:0] radius;
  } frame_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [ACTION_W-1:0] in_action = '0;
  logic [POS_W-1:0] in_pos_x = '0;
  logic [POS_W-1:0] in_pos_y = '0;
  logic [RADIUS_W-1:0] in_radius = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_cell_value;
  logic [ACTION_W-1:0] out_done_action;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  filled_circle_framebuffer uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_action(in_action), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_radius(in_radius),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_cell_value(out_cell_value), .out_done_action(out_done_action),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  bit frame_bits [0:MAX_COLS*MAX_ROWS_TB-1];
  logic [COLS_W-1:0] cols_reg = fbc_pkg::RESET_ACTIVE_COLUMNS;
  logic [ROWS_W-1:0] rows_reg = fbc_pkg::RESET_ACTIVE_ROWS;

  frame_req_t pending_reqs[$];
  fbc_pkg::result_t results_due[$];
  frame_req_t cur_req;
  fbc_pkg::result_t want;

  int send_idle_pct = 31;
  int pop_idle_pct = 31;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int last_x = 0;
  int last_y = 0;
  int errors = 0;
  int cycle_count = 0;

  function automatic int eff_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int eff_rows();
    return (rows_reg > MAX_ROWS_TB) ? MAX_ROWS_TB : int'(rows_reg);
  endfunction

  function automatic fbc_pkg::result_t predict_frame(frame_req_t r);
    fbc_pkg::result_t res;
    int cols, rows, cx, cy, rad;
    cols = eff_cols();
    rows = eff_rows();
    cx = $signed(r.pos_x);
    cy = $signed(r.pos_y);
    rad = r.radius;
    res.cell_value = 1'b0;
    res.done_action = r.act;
    case (r.act)
      fbc_pkg::ACT_CLEAR: begin
        foreach (frame_bits[i]) frame_bits[i] = 1'b0;
      end
      fbc_pkg::ACT_DRAW: begin
        for (int row = 0; row < rows; row++)
          for (int col = 0; col < cols; col++)
            if ((col - cx) * (col - cx) + (row - cy) * (row - cy) <= rad * rad)
              frame_bits[row * MAX_COLS + col] = 1'b1;
      end
      fbc_pkg::ACT_READ: begin
        if (cx >= 0 && cy >= 0 && cx < cols && cy < rows)
          res.cell_value = frame_bits[cy * MAX_COLS + cx];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("MISMATCH cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, exp_v);
    errors++;
  endtask

  task automatic queue_req(fbc_pkg::action_t a, int x, int y, int r);
    frame_req_t q;
    q.act = a;
    q.pos_x = POS_W'(x);
    q.pos_y = POS_W'(y);
    q.radius = RADIUS_W'(r);
    pending_reqs.push_back(q);
  endtask

  function automatic frame_req_t random_req();
    frame_req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) r.act = fbc_pkg::ACT_CLEAR;
    else if (pick < 42) r.act = fbc_pkg::ACT_DRAW;
    else if (pick < 92) r.act = fbc_pkg::ACT_READ;
    else r.act = fbc_pkg::ACT_NONE;
    pick = $urandom_range(9);
    if (pick == 0) begin
      r.pos_x = POS_W'($urandom);
      r.pos_y = POS_W'($urandom);
    end else if (r.act == fbc_pkg::ACT_READ && pick < 6) begin
      r.pos_x = POS_W'(last_x + int'($urandom_range(8)) - 4);
      r.pos_y = POS_W'(last_y + int'($urandom_range(8)) - 4);
    end else begin
      r.pos_x = POS_W'(int'($urandom_range(eff_cols() + 3)) - 2);
      r.pos_y = POS_W'(int'($urandom_range(eff_rows() + 3)) - 2);
    end
    pick = $urandom_range(99);
    if (pick < 3) r.radius = RADIUS_W'($urandom);
    else if (pick < 15) r.radius = RADIUS_W'($urandom_range(20));
    else r.radius = RADIUS_W'($urandom_range(5));
    if (r.act == fbc_pkg::ACT_DRAW) begin
      last_x = $signed(r.pos_x);
      last_y = $signed(r.pos_y);
    end
    return r;
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_reqs.push_back(random_req());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_push || results_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == fbc_pkg::CFG_ACTIVE_COLUMNS) cols_reg = data;
    else rows_reg = data[ROWS_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** filled_circle_framebuffer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) results_due.push_back(predict_frame(cur_req));
      if (!in_push || !in_full) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_action <= cur_req.act;
          in_pos_x <= cur_req.pos_x;
          in_pos_y <= cur_req.pos_y;
          in_radius <= cur_req.radius;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with no request pending", int'(out_done_action), -1);
      end else begin
        want = results_due.pop_front();
        if (out_cell_value !== want.cell_value)
          report_mismatch("cell_value", int'(out_cell_value), int'(want.cell_value));
        if (out_done_action !== want.done_action)
          report_mismatch("done_action", int'(out_done_action), int'(want.done_action));
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = POP_HOLD;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
    out_pop <= (hold_left == 0) && ($urandom_range(99) >= pop_idle_pct);
  end

  initial begin
    foreach (frame_bits[i]) frame_bits[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_req(fbc_pkg::ACT_READ, 5, 5, 0);
    queue_req(fbc_pkg::ACT_DRAW, 0, 0, 0);
    queue_req(fbc_pkg::ACT_READ, 0, 0, 0);
    queue_req(fbc_pkg::ACT_READ, -1, 0, 0);
    queue_req(fbc_pkg::ACT_READ, 0, -256, 0);
    queue_req(fbc_pkg::ACT_DRAW, 99, 29, 2);
    queue_req(fbc_pkg::ACT_READ, 99, 29, 0);
    queue_req(fbc_pkg::ACT_READ, 100, 29, 0);
    queue_req(fbc_pkg::ACT_READ, 99, 30, 0);
    queue_req(fbc_pkg::ACT_DRAW, 255, 255, 127);
    queue_req(fbc_pkg::ACT_DRAW, -256, -256, 127);
    queue_req(fbc_pkg::ACT_NONE, 255, -1, 127);
    queue_req(fbc_pkg::ACT_DRAW, 50, 15, 1);
    queue_req(fbc_pkg::ACT_READ, 51, 15, 0);
    queue_req(fbc_pkg::ACT_READ, 51, 16, 0);
    queue_req(fbc_pkg::ACT_CLEAR, 0, 0, 0);
    queue_req(fbc_pkg::ACT_READ, 0, 0, 0);
    queue_req(fbc_pkg::ACT_DRAW, 50, 15, 127);
    queue_req(fbc_pkg::ACT_READ, 99, 0, 0);
    queue_req(fbc_pkg::ACT_READ, 255, 255, 0);
    queue_req(fbc_pkg::ACT_CLEAR, -256, 255, 127);
    queue_req(fbc_pkg::ACT_DRAW, 10, 10, 3);
    queue_req(fbc_pkg::ACT_READ, 13, 10, 0);
    wait_idle();

    // Oversized values clamp to the full store.
    write_reg(fbc_pkg::CFG_ACTIVE_COLUMNS, 8'hFF);
    write_reg(fbc_pkg::CFG_ACTIVE_ROWS, 8'hFF);
    queue_req(fbc_pkg::ACT_DRAW, 127, 31, 0);
    queue_req(fbc_pkg::ACT_READ, 127, 31, 0);
    queue_random(35);
    wait_idle();

    write_reg(fbc_pkg::CFG_ACTIVE_COLUMNS, 8'h00);
    write_reg(fbc_pkg::CFG_ACTIVE_ROWS, 8'h00);
    queue_random(10);
    wait_idle();

    write_reg(fbc_pkg::CFG_ACTIVE_COLUMNS, 8'd1);
    write_reg(fbc_pkg::CFG_ACTIVE_ROWS, 8'd1);
    queue_random(10);
    wait_idle();

    send_idle_pct = 0;
    pop_idle_pct = 0;
    write_reg(fbc_pkg::CFG_ACTIVE_COLUMNS, 8'd20);
    write_reg(fbc_pkg::CFG_ACTIVE_ROWS, 8'hC8);
    queue_random(25);
    wait_idle();

    // Growing the area again exposes cells drawn before the shrink.
    write_reg(fbc_pkg::CFG_ACTIVE_COLUMNS, 8'd128);
    write_reg(fbc_pkg::CFG_ACTIVE_ROWS, 8'hE0);
    hold_requests = hold_requests + 1;
    repeat (16) queue_req(fbc_pkg::ACT_READ, $urandom_range(127), $urandom_range(31), 0);
    wait_idle();
    send_idle_pct = 31;
    pop_idle_pct = 31;
    queue_random(20);
    wait_idle();

    if (errors == 0) begin
      $display("** filled_circle_framebuffer: PASSED **");
    end else begin
      $display("** filled_circle_framebuffer: FAILED **");
    end
    $finish;
  end

endmodule
